[sv/stok_pkg.sv]
package stok_pkg;

  typedef enum logic [5:0] {
    KIND_IDENT    = 6'd0,
    KIND_INT      = 6'd1,
    KIND_DECIMAL  = 6'd2,
    KIND_STRING   = 6'd3,
    KIND_BOOL     = 6'd4,
    KIND_PUBLIC   = 6'd5,
    KIND_FUNCTION = 6'd6,
    KIND_RETURN   = 6'd7,
    KIND_CLASS    = 6'd8,
    KIND_ABSTRACT = 6'd9,
    KIND_STATIC   = 6'd10,
    KIND_IS       = 6'd11,
    KIND_IF       = 6'd12,
    KIND_ELSE     = 6'd13,
    KIND_WHILE    = 6'd14,
    KIND_FOR      = 6'd15,
    KIND_LBRACE   = 6'd16,
    KIND_RBRACE   = 6'd17,
    KIND_LPAREN   = 6'd18,
    KIND_RPAREN   = 6'd19,
    KIND_ASSIGN   = 6'd20,
    KIND_SEMI     = 6'd21,
    KIND_COMMA    = 6'd22,
    KIND_LBRACKET = 6'd23,
    KIND_RBRACKET = 6'd24,
    KIND_PLUS     = 6'd25,
    KIND_MINUS    = 6'd26,
    KIND_STAR     = 6'd27,
    KIND_SLASH    = 6'd28,
    KIND_EQ       = 6'd29,
    KIND_NE       = 6'd30,
    KIND_LT       = 6'd31,
    KIND_LE       = 6'd32,
    KIND_GT       = 6'd33,
    KIND_GE       = 6'd34,
    KIND_EOF      = 6'd35
  } kind_e;

  localparam int IQ_DEPTH = 4;
  localparam int TQ_DEPTH = 4;
  localparam int KW_NUM   = 13;

  // keyword text left-justified: first character in the top byte
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    {"public", 16'h0}, {"function"}, {"return", 16'h0}, {"class", 24'h0},
    {"abstract"}, {"static", 16'h0}, {"is", 48'h0}, {"if", 48'h0},
    {"else", 32'h0}, {"while", 24'h0}, {"for", 40'h0}, {"true", 32'h0},
    {"false", 24'h0}
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd6, 4'd8, 4'd6, 4'd5, 4'd8, 4'd6, 4'd2, 4'd2, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5
  };
  localparam kind_e KW_KIND [KW_NUM] = '{
    KIND_PUBLIC, KIND_FUNCTION, KIND_RETURN, KIND_CLASS, KIND_ABSTRACT,
    KIND_STATIC, KIND_IS, KIND_IF, KIND_ELSE, KIND_WHILE, KIND_FOR,
    KIND_BOOL, KIND_BOOL
  };

  typedef struct packed {
    logic  alpha;
    logic  digit;
    logic  ws;
    logic  nl;
    logic  quote;
    logic  bslash;
    logic  dot;
    logic  eq;
    logic  opst;
    logic  sym;
    kind_e sym_kind;
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
    cls_t       cls;
  } item_t;

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    r = '0;
    r.sym_kind = KIND_IDENT;
    r.alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    r.digit  = c >= "0" && c <= "9";
    r.ws     = c == " " || (c >= 8'd9 && c <= 8'd13);
    r.nl     = c == 8'd10;
    r.quote  = c == 8'h22;
    r.bslash = c == 8'h5c;
    r.dot    = c == ".";
    r.eq     = c == "=";
    r.opst   = c == "=" || c == "!" || c == "<" || c == ">";
    r.sym    = 1'b1;
    unique case (c)
      "{": r.sym_kind = KIND_LBRACE;
      "}": r.sym_kind = KIND_RBRACE;
      "(": r.sym_kind = KIND_LPAREN;
      ")": r.sym_kind = KIND_RPAREN;
      ";": r.sym_kind = KIND_SEMI;
      ",": r.sym_kind = KIND_COMMA;
      "[": r.sym_kind = KIND_LBRACKET;
      "]": r.sym_kind = KIND_RBRACKET;
      "+": r.sym_kind = KIND_PLUS;
      "-": r.sym_kind = KIND_MINUS;
      "*": r.sym_kind = KIND_STAR;
      "/": r.sym_kind = KIND_SLASH;
      default: r.sym = 1'b0;
    endcase
    return r;
  endfunction

  // len is 15 when the word is longer than any keyword
  function automatic kind_e kw_kind(logic [63:0] text, logic [3:0] len);
    kind_e k;
    k = KIND_IDENT;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && text == KW_TEXT[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

endpackage

[sv/stok_front.sv]
module stok_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [7:0]      ch_i,
  input  logic            end_i,
  output logic            item_valid_o,
  output stok_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import stok_pkg::*;

  localparam int AW = $clog2(IQ_DEPTH);

  item_t         mem_q [IQ_DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign s_ready_o    = cnt_q != (AW+1)'(IQ_DEPTH);
  assign item_valid_o = cnt_q != '0;
  assign item_o       = mem_q[rptr_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{ch: ch_i, end_mark: end_i, cls: classify(ch_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + AW'(1);
      if (pop) rptr_q <= rptr_q + AW'(1);
      if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

[sv/stok_scan.sv]
module stok_scan #(
  parameter int PREFIX_BYTES = 8,
  parameter int OFFSET_BITS  = 32,
  parameter int LINE_BITS    = 24,
  parameter int LENGTH_BITS  = 16,
  parameter int TOK_W        = 6 + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  stok_pkg::item_t  item_i,
  output logic             item_ready_o,
  input  logic             room_i,
  output logic [1:0]       push_cnt_o,
  output logic [TOK_W-1:0] tok0_o,
  output logic [TOK_W-1:0] tok1_o
);
  import stok_pkg::*;

  localparam int PB_W = $clog2(PREFIX_BYTES);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_WORD = 3'd1;
  localparam logic [2:0] MODE_NUM  = 3'd2;
  localparam logic [2:0] MODE_STR  = 3'd3;
  localparam logic [2:0] MODE_ESC  = 3'd4;
  localparam logic [2:0] MODE_OP   = 3'd5;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  logic [2:0]                        mode_q, mode_d;
  logic [7:0]                        pend_q, pend_d;
  logic [PREFIX_BYTES-1:0][7:0]      prefix_q, prefix_d;
  logic [OFFSET_BITS-1:0]            begin_q, begin_d;
  logic [LENGTH_BITS-1:0]            cnt_q, cnt_d;
  logic                              seen_q, seen_d;
  logic [LINE_BITS-1:0]              line_q, line_d;
  logic [OFFSET_BITS-1:0]            off_q, off_d;

  cls_t                   cls;
  logic                   fire;
  logic [63:0]            word_text;
  logic [3:0]             word_len;
  kind_e                  fl_kind;
  logic                   fl_v;
  logic [LENGTH_BITS-1:0] fl_len;

  logic                   e0_v, e1_v;
  kind_e                  e0_kind, e1_kind;
  logic [OFFSET_BITS-1:0] e0_start, e1_start, begin_val;
  logic [LENGTH_BITS-1:0] e0_len, e1_len;
  logic                   do_begin, do_count, consumed;

  assign cls          = item_i.cls;
  assign item_ready_o = room_i;
  assign fire         = item_valid_i && room_i;

  always_comb begin
    for (int i = 0; i < 8; i++) word_text[63-8*i -: 8] = prefix_q[i];
  end
  assign word_len = (cnt_q <= LENGTH_BITS'(8)) ? cnt_q[3:0] : 4'd15;

  // token left pending by the current mode
  always_comb begin
    fl_v    = 1'b1;
    fl_kind = KIND_IDENT;
    fl_len  = cnt_q;
    unique case (mode_q)
      MODE_WORD: fl_kind = kw_kind(word_text, word_len);
      MODE_NUM:  fl_kind = seen_q ? KIND_DECIMAL : KIND_INT;
      MODE_STR, MODE_ESC: fl_kind = KIND_STRING;
      MODE_OP: begin
        fl_len = LENGTH_BITS'(1);
        priority if (pend_q == "=") fl_kind = KIND_ASSIGN;
        else if (pend_q == "<") fl_kind = KIND_LT;
        else if (pend_q == ">") fl_kind = KIND_GT;
        else fl_v = 1'b0;
      end
      default: fl_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    pend_d    = pend_q;
    prefix_d  = prefix_q;
    begin_d   = begin_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    line_d    = line_q;
    off_d     = off_q;
    e0_v      = 1'b0;
    e0_kind   = fl_kind;
    e0_start  = begin_q;
    e0_len    = fl_len;
    e1_v      = 1'b0;
    e1_kind   = cls.sym_kind;
    e1_start  = off_q;
    e1_len    = LENGTH_BITS'(1);
    do_begin  = 1'b0;
    do_count  = 1'b0;
    consumed  = 1'b0;
    begin_val = off_q;

    if (item_i.end_mark) begin
      e0_v     = fl_v;
      e1_v     = 1'b1;
      e1_kind  = KIND_EOF;
      e1_len   = '0;
      mode_d   = MODE_IDLE;
      pend_d   = '0;
      prefix_d = '0;
      begin_d  = '0;
      cnt_d    = '0;
      seen_d   = 1'b0;
      line_d   = LINE_BITS'(1);
      off_d    = '0;
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (cls.alpha || cls.digit) begin
            do_count = 1'b1;
            consumed = 1'b1;
          end else begin
            e0_v   = fl_v;
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (cls.digit || (cls.dot && !seen_q)) begin
            if (cls.dot) seen_d = 1'b1;
            do_count = 1'b1;
            consumed = 1'b1;
          end else begin
            e0_v   = fl_v;
            mode_d = MODE_IDLE;
          end
        end
        MODE_STR: begin
          consumed = 1'b1;
          if (cls.quote) begin
            e0_v    = 1'b1;
            e0_kind = KIND_STRING;
            e0_len  = cnt_q;
            mode_d  = MODE_IDLE;
          end else begin
            do_count = 1'b1;
            if (cls.bslash) mode_d = MODE_ESC;
          end
        end
        MODE_ESC: begin
          consumed = 1'b1;
          do_count = 1'b1;
          mode_d   = MODE_STR;
        end
        MODE_OP: begin
          if (cls.eq) begin
            consumed = 1'b1;
            e0_v     = 1'b1;
            e0_len   = LENGTH_BITS'(2);
            mode_d   = MODE_IDLE;
            priority if (pend_q == "=") e0_kind = KIND_EQ;
            else if (pend_q == "!") e0_kind = KIND_NE;
            else if (pend_q == "<") e0_kind = KIND_LE;
            else e0_kind = KIND_GE;
          end else begin
            e0_v   = fl_v;
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      // byte seen fresh, between tokens
      if (!consumed) begin
        priority if (cls.ws) begin
          if (cls.nl && line_q != LINE_MAX) line_d = line_q + LINE_BITS'(1);
        end else if (cls.alpha) begin
          do_begin = 1'b1;
          do_count = 1'b1;
          mode_d   = MODE_WORD;
        end else if (cls.digit) begin
          do_begin = 1'b1;
          do_count = 1'b1;
          mode_d   = MODE_NUM;
        end else if (cls.quote) begin
          do_begin  = 1'b1;
          mode_d    = MODE_STR;
          begin_val = (off_q != OFF_MAX) ? off_q + OFFSET_BITS'(1) : off_q;
        end else if (cls.opst) begin
          do_begin = 1'b1;
          mode_d   = MODE_OP;
          pend_d   = item_i.ch;
        end else if (cls.sym) begin
          e1_v = 1'b1;
        end
      end

      if (do_begin) begin
        begin_d  = begin_val;
        cnt_d    = '0;
        prefix_d = '0;
        seen_d   = 1'b0;
      end
      if (do_count) begin
        if (cnt_d < LENGTH_BITS'(PREFIX_BYTES)) prefix_d[cnt_d[PB_W-1:0]] = item_i.ch;
        if (cnt_d != LEN_MAX) cnt_d = cnt_d + LENGTH_BITS'(1);
      end
      off_d = (off_q != OFF_MAX) ? off_q + OFFSET_BITS'(1) : off_q;
    end
  end

  // first token goes to slot 0; last flag on the final one
  always_comb begin
    if (e0_v) begin
      tok0_o     = {!e1_v, e0_len, e0_start, line_q, e0_kind};
      tok1_o     = {1'b1, e1_len, e1_start, line_q, e1_kind};
      push_cnt_o = e1_v ? 2'd2 : 2'd1;
    end else begin
      tok0_o     = {1'b1, e1_len, e1_start, line_q, e1_kind};
      tok1_o     = tok0_o;
      push_cnt_o = e1_v ? 2'd1 : 2'd0;
    end
    if (!fire) push_cnt_o = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= '0;
      prefix_q <= '0;
      begin_q  <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      line_q   <= LINE_BITS'(1);
      off_q    <= '0;
    end else if (fire) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      prefix_q <= prefix_d;
      begin_q  <= begin_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      line_q   <= line_d;
      off_q    <= off_d;
    end
  end

endmodule

[sv/stok_outq.sv]
module stok_outq #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] din0_i,
  input  logic [WIDTH-1:0] din1_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] dout_o
);
  import stok_pkg::*;

  localparam int AW = $clog2(TQ_DEPTH);

  logic [WIDTH-1:0] mem_q [TQ_DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             pop;

  // room for the two transfers one item can cause
  assign room_o  = cnt_q <= (AW+1)'(TQ_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign dout_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wptr_q] <= din0_i;
    if (push_cnt_i == 2'd2) mem_q[wptr_q + AW'(1)] <= din1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + AW'(push_cnt_i);
      if (pop) rptr_q <= rptr_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_cnt_i) - (AW+1)'(pop);
    end
  end

endmodule

[sv/source_tokenizer_unit.sv]
// Streaming source tokenizer. Each input transfer carries one source byte in
// tdata, or an end mark in tuser that flushes any pending token, emits the
// end-of-input token and restarts the line and offset counters. Tokens leave
// as kind, line, start offset and length, with tlast on the final token that
// an input transfer causes. The block takes one transfer per clock unless the
// queues fill: a four-entry queue holds classified bytes, a scanner with
// registered state handles one byte each clock while it has room, and a
// four-entry token queue that can take two tokens in one cycle feeds the
// output. The scanner works on a byte when at least two token slots are free,
// so the rate stays at one byte per clock while the output drains at least one
// token per clock on average. Bytes and tokens are registered in the queues.
module source_tokenizer_unit #(
  parameter int PREFIX_BYTES = 8,
  parameter int OFFSET_BITS  = 32,
  parameter int LINE_BITS    = 24,
  parameter int LENGTH_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // ch
  input  logic s_axis_tuser,        // end_mark
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // token_kind, token_line, token_start, token_length, zero fill
  output logic [((6 + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast         // last_of_run
);
  import stok_pkg::*;

  localparam int PAY_W  = 6 + LINE_BITS + OFFSET_BITS + LENGTH_BITS;
  localparam int DATA_W = ((PAY_W + 7) / 8) * 8;
  localparam int TOK_W  = PAY_W + 1;

  logic             item_valid, item_ready, room;
  item_t            item;
  logic [1:0]       push_cnt;
  logic [TOK_W-1:0] tok0, tok1, tok_out;

  stok_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .ch_i         (s_axis_tdata),
    .end_i        (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  stok_scan #(
    .PREFIX_BYTES (PREFIX_BYTES),
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_BITS    (LINE_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .TOK_W        (TOK_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .room_i       (room),
    .push_cnt_o   (push_cnt),
    .tok0_o       (tok0),
    .tok1_o       (tok1)
  );

  stok_outq #(
    .WIDTH (TOK_W)
  ) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .din0_i     (tok0),
    .din1_i     (tok1),
    .room_o     (room),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .dout_o     (tok_out)
  );

  assign m_axis_tdata = DATA_W'(tok_out[PAY_W-1:0]);
  assign m_axis_tlast = tok_out[TOK_W-1];

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  localparam int TDATA_W     = ((6 + 24 + 32 + 16 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_BYTES = 770;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_STR, SCAN_ESC, SCAN_OP
  } scan_e;

  typedef enum int {RX_STEADY, RX_HALF, RX_LIGHT, RX_HEAVY} rx_mode_e;

  typedef struct {
    logic [7:0] ch;
    logic       end_mark;
  } src_item_t;

  typedef struct {
    kind_e       kind;
    logic [23:0] line;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  source_tokenizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  string kw_word [13] = '{"public", "function", "return", "class", "abstract", "static",
                          "is", "if", "else", "while", "for", "true", "false"};
  kind_e kw_code [13] = '{KIND_PUBLIC, KIND_FUNCTION, KIND_RETURN, KIND_CLASS,
                          KIND_ABSTRACT, KIND_STATIC, KIND_IS, KIND_IF, KIND_ELSE,
                          KIND_WHILE, KIND_FOR, KIND_BOOL, KIND_BOOL};
  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string sym_chars   = "{}()=;,[]+-*/";
  string op_chars    = "=!<>";

  src_item_t src_q[$];
  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  int        pushed_bytes = 0;
  int        errors = 0;
  int        cycles = 0;
  bit        byte_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_left = 0;
  rx_mode_e  rx_mode = RX_STEADY;

  // scanner shadow state
  scan_e       sc_mode;
  logic [7:0]  op_char;
  logic [7:0]  word_text [8];
  logic [31:0] tok_begin;
  logic [15:0] tok_len;
  logic        point_seen;
  logic [23:0] cur_line;
  logic [31:0] cur_offset;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic reset_scan();
    sc_mode = SCAN_IDLE;
    op_char = 8'h00;
    foreach (word_text[i]) word_text[i] = 8'h00;
    tok_begin = '0;
    tok_len = '0;
    point_seen = 1'b0;
    cur_line = 24'd1;
    cur_offset = '0;
  endtask

  task automatic note_token(kind_e k, logic [31:0] s, logic [15:0] n);
    token_t t;
    t.kind = k;
    t.line = cur_line;
    t.start = s;
    t.len = n;
    t.last = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic add_text(logic [7:0] c);
    if (tok_len < 8) word_text[tok_len] = c;
    if (tok_len != '1) tok_len++;
  endtask

  function automatic kind_e word_class();
    bit hit;
    for (int i = 0; i < 13; i++) begin
      if (tok_len == kw_word[i].len()) begin
        hit = 1'b1;
        for (int j = 0; j < kw_word[i].len(); j++)
          if (word_text[j] != kw_word[i][j]) hit = 1'b0;
        if (hit) return kw_code[i];
      end
    end
    return KIND_IDENT;
  endfunction

  task automatic open_token(scan_e m, logic [31:0] s);
    sc_mode = m;
    tok_begin = s;
    tok_len = '0;
    point_seen = 1'b0;
    foreach (word_text[i]) word_text[i] = 8'h00;
  endtask

  task automatic close_token();
    case (sc_mode)
      SCAN_WORD: note_token(word_class(), tok_begin, tok_len);
      SCAN_NUM: note_token(point_seen ? KIND_DECIMAL : KIND_INT, tok_begin, tok_len);
      SCAN_STR, SCAN_ESC: note_token(KIND_STRING, tok_begin, tok_len);
      SCAN_OP: begin
        if (op_char == "=") note_token(KIND_ASSIGN, tok_begin, 16'd1);
        else if (op_char == "<") note_token(KIND_LT, tok_begin, 16'd1);
        else if (op_char == ">") note_token(KIND_GT, tok_begin, 16'd1);
      end
      default: ;
    endcase
    sc_mode = SCAN_IDLE;
  endtask

  task automatic fresh_byte(logic [7:0] c, logic [31:0] off);
    kind_e k;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == 8'd10 && cur_line != '1) cur_line++;
      return;
    end
    if (is_letter(c)) begin
      open_token(SCAN_WORD, off);
      add_text(c);
      return;
    end
    if (is_numeral(c)) begin
      open_token(SCAN_NUM, off);
      add_text(c);
      return;
    end
    // string text starts after the opening quote
    if (c == 8'h22) begin
      open_token(SCAN_STR, off != '1 ? off + 32'd1 : off);
      return;
    end
    if (c == "=" || c == "!" || c == "<" || c == ">") begin
      open_token(SCAN_OP, off);
      op_char = c;
      return;
    end
    case (c)
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      ";": k = KIND_SEMI;
      ",": k = KIND_COMMA;
      "[": k = KIND_LBRACKET;
      "]": k = KIND_RBRACKET;
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "*": k = KIND_STAR;
      "/": k = KIND_SLASH;
      default: return;
    endcase
    note_token(k, off, 16'd1);
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic [31:0] off;
    bit used;
    kind_e k;
    off = cur_offset;
    used = 1'b0;
    case (sc_mode)
      SCAN_WORD: begin
        if (is_letter(c) || is_numeral(c)) begin
          add_text(c);
          used = 1'b1;
        end else close_token();
      end
      SCAN_NUM: begin
        if (is_numeral(c) || (c == "." && !point_seen)) begin
          if (c == ".") point_seen = 1'b1;
          add_text(c);
          used = 1'b1;
        end else close_token();
      end
      SCAN_STR: begin
        if (c == 8'h22) begin
          note_token(KIND_STRING, tok_begin, tok_len);
          sc_mode = SCAN_IDLE;
        end else begin
          add_text(c);
          if (c == 8'h5c) sc_mode = SCAN_ESC;
        end
        used = 1'b1;
      end
      SCAN_ESC: begin
        add_text(c);
        sc_mode = SCAN_STR;
        used = 1'b1;
      end
      SCAN_OP: begin
        if (c == "=") begin
          if (op_char == "=") k = KIND_EQ;
          else if (op_char == "!") k = KIND_NE;
          else if (op_char == "<") k = KIND_LE;
          else k = KIND_GE;
          note_token(k, tok_begin, 16'd2);
          sc_mode = SCAN_IDLE;
          used = 1'b1;
        end else close_token();
      end
      default: sc_mode = SCAN_IDLE;
    endcase
    if (!used) fresh_byte(c, off);
    if (cur_offset != '1) cur_offset++;
  endtask

  task automatic tokenize_item(logic [7:0] c, logic end_mark);
    if (end_mark) begin
      close_token();
      note_token(KIND_EOF, cur_offset, 16'd0);
      reset_scan();
    end else begin
      scan_byte(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    step_tokens.delete();
  endtask

  task automatic report_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 50)
        $display("%0t tb: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      errors++;
      if (errors <= 50)
        $display("%0t tb: unexpected token, expected none, got %h", $time, m_axis_tdata);
      return;
    end
    want = expected_tokens.pop_front();
    report_field("kind", 32'(want.kind), 32'(m_axis_tdata[5:0]));
    report_field("line", 32'(want.line), 32'(m_axis_tdata[29:6]));
    report_field("start", want.start, m_axis_tdata[61:30]);
    report_field("length", 32'(want.len), 32'(m_axis_tdata[77:62]));
    report_field("tlast", 32'(want.last), 32'(m_axis_tlast));
  endtask

  task automatic push_byte(logic [7:0] c);
    src_item_t it;
    it.ch = c;
    it.end_mark = 1'b0;
    src_q.insert(src_q.size(), it);
    pushed_bytes++;
  endtask

  task automatic push_end();
    src_item_t it;
    it.ch = 8'($urandom_range(0, 255));
    it.end_mark = 1'b1;
    src_q.insert(src_q.size(), it);
    pushed_bytes++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // one lexical fragment, mostly well-formed, some noise
  task automatic gen_fragment();
    int n;
    string w;
    case ($urandom_range(0, 19))
      0, 1: begin
        w = kw_word[$urandom_range(0, 12)];
        case ($urandom_range(0, 3))
          0: push_text(w.substr(0, $urandom_range(0, w.len() - 1)));
          1: begin
            push_text(w);
            push_byte(ident_chars[$urandom_range(0, 62)]);
          end
          default: push_text(w);
        endcase
      end
      2, 3, 4: begin
        n = $urandom_range(1, 12);
        push_byte(ident_chars[$urandom_range(0, 52)]);
        for (int i = 1; i < n; i++) push_byte(ident_chars[$urandom_range(0, 62)]);
      end
      5, 6, 7: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          push_byte(".");
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 3) == 0) begin
            push_byte(".");
            push_byte(8'("0" + $urandom_range(0, 9)));
          end
        end
      end
      8, 9: begin
        push_byte(8'h22);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: begin
              push_byte(8'h5c);
              push_byte(8'($urandom_range(0, 255)));
            end
            1: push_byte(8'd10);
            2: push_byte(8'($urandom_range(128, 255)));
            default: push_byte(8'($urandom_range(32, 126)) == 8'h22 ? "q" :
                               8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) push_byte(8'h22);
      end
      10, 11: begin
        push_byte(op_chars[$urandom_range(0, 3)]);
        if ($urandom_range(0, 1)) push_byte("=");
      end
      12, 13: push_byte(sym_chars[$urandom_range(0, 12)]);
      14, 15: begin
        n = $urandom_range(0, 5);
        push_byte(n == 5 ? " " : 8'(9 + n));
      end
      16: push_byte(8'($urandom_range(0, 255)));
      17: push_byte(8'($urandom_range(128, 255)));
      18: push_end();
      default: push_byte(".");
    endcase
    if ($urandom_range(0, 2) == 0) push_byte(" ");
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) void'(src_q.pop_front());
      if (!(s_axis_tvalid && !byte_taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (src_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= src_q[0].ch;
          s_axis_tuser <= src_q[0].end_mark;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between a few densities
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STEADY: m_axis_tready <= 1'b1;
      RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
      RX_LIGHT: m_axis_tready <= $urandom_range(0, 7) != 0;
      default: m_axis_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken = s_axis_tvalid && s_axis_tready;
      if (byte_taken) tokenize_item(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_token();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int start_count;
    reset_scan();

    // extremes, lookahead, second point, lone bang, end resolving an operator
    push_byte(8'h00);
    push_byte(8'hff);
    push_text("if(a1>=2.5.7)!x<");
    push_end();
    // open string at end with a trailing escape
    push_text("\"a\\");
    push_end();

    start_count = pushed_bytes;
    while (pushed_bytes - start_count < RANDOM_BYTES) gen_fragment();
    push_end();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (src_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
